FILE: src/stlg_pkg.sv
// package for the shuffle table lcg generator
// holds the sequencer states, lcg constants and the multiply-add operand type
// no dependencies

package stlg_pkg;

    localparam int WORD_W = 16;
    localparam int PROD_W = 32;

    localparam logic [WORD_W-1:0] LCG_MUL  = 16'd25173;
    localparam logic [WORD_W-1:0] LCG_ADD  = 16'd13849;
    localparam logic [WORD_W-1:0] WORD_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CALC,
        ST_READ,
        ST_NEXT
    } state_t;

    // operands of the shared multiply-add unit: a * b + c
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } mac_op_t;

endpackage

FILE: src/stlg_mac.sv
// shared 16x16 multiply-add unit, full 32-bit result
// depends on stlg_pkg

module stlg_mac (
    input  stlg_pkg::mac_op_t            op,
    output logic [stlg_pkg::PROD_W-1:0]  result
);

    logic [stlg_pkg::PROD_W-1:0] prod;

    assign prod   = stlg_pkg::PROD_W'(op.a) * stlg_pkg::PROD_W'(op.b);
    assign result = prod + stlg_pkg::PROD_W'(op.c);

endmodule

FILE: src/shuffle_table_lcg_generator.sv
// top level of the shuffle table lcg generator: sequencer, table memory, output register
// depends on stlg_pkg and stlg_mac

// channel   | dir | ports                          | word
// ----------+-----+--------------------------------+-------------------------
// seed in   | in  | s_tvalid, s_tready, s_tdata    | [15:0] seed
// value out | out | m_tvalid, m_tready, m_tdata    | [15:0] value
//
// a normal word goes through accept, index multiply, table read, lcg step and write
// the first word after reset also runs the table fill over all TABLE_DEPTH entries first
// every multiply-add goes through the one shared multiply-add unit, one use per cycle
// reset (aresetn, synchronous, active low) clears the sequencer, output valid and fill address and sets the fill flag
// the result sits in an output register; the block stalls in its last step only
// while an earlier word is still waiting there

module shuffle_table_lcg_generator #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] seed

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] value
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int W     = stlg_pkg::WORD_W;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [W-1:0]     LAST_WIDE = W'(TABLE_DEPTH - 1);

    stlg_pkg::state_t state_reg, state_next;

    logic                         fill_reg;      // table fill pending
    logic [W-1:0]                 seed_reg;
    logic [W-1:0]                 x_reg;         // running lcg value during fill
    logic [W-1:0]                 e0_reg;        // copy of entry 0, the index source
    logic [IDX_W-1:0]             cnt_reg;       // fill address
    logic [IDX_W-1:0]             idx_reg;
    logic [stlg_pkg::PROD_W-1:0]  prod_reg;
    logic [W-1:0]                 rdata_reg;
    logic                         m_valid_reg;
    logic [W-1:0]                 m_data_reg;

    logic [W-1:0] mem [TABLE_DEPTH];

    // shared unit
    stlg_pkg::mac_op_t            mac_op;
    logic [stlg_pkg::PROD_W-1:0]  mac_res;
    logic [W-1:0]                 lcg_val;

    stlg_mac u_mac (
        .op     (mac_op),
        .result (mac_res)
    );

    assign lcg_val = mac_res[W-1:0];

    // index = floor(prod / 65535), using 65535 = 2^16 - 1
    logic [W-1:0]   q0;
    logic [W:0]     rem;
    logic [W-1:0]   q;
    logic [IDX_W-1:0] idx_calc;

    always_comb begin
        q0  = prod_reg[stlg_pkg::PROD_W-1:W];
        rem = {1'b0, prod_reg[W-1:0]} + {1'b0, q0};
        q   = q0;
        if (rem >= {1'b0, stlg_pkg::WORD_MAX}) begin
            q = q0 + W'(1);
        end
        if (q > LAST_WIDE) begin
            idx_calc = IDX_LAST;
        end else begin
            idx_calc = q[IDX_W-1:0];
        end
    end

    logic s_fire;
    logic out_free;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stlg_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = fill_reg ? stlg_pkg::ST_FILL : stlg_pkg::ST_CALC;
                end
            end
            stlg_pkg::ST_FILL: begin
                if (cnt_reg == IDX_LAST) begin
                    state_next = stlg_pkg::ST_CALC;
                end
            end
            stlg_pkg::ST_CALC: state_next = stlg_pkg::ST_READ;
            stlg_pkg::ST_READ: state_next = stlg_pkg::ST_NEXT;
            stlg_pkg::ST_NEXT: begin
                if (out_free) begin
                    state_next = stlg_pkg::ST_IDLE;
                end
            end
            default: state_next = stlg_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic             out_load;

    always_comb begin
        s_tready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = cnt_reg;
        rd_en    = 1'b0;
        out_load = 1'b0;
        mac_op.a = seed_reg;
        mac_op.b = stlg_pkg::LCG_MUL;
        mac_op.c = stlg_pkg::LCG_ADD;
        case (state_reg)
            stlg_pkg::ST_IDLE: s_tready = 1'b1;
            stlg_pkg::ST_FILL: begin
                mac_op.a = x_reg;
                wr_en    = 1'b1;
            end
            stlg_pkg::ST_CALC: begin
                mac_op.a = e0_reg;
                mac_op.b = LAST_WIDE;
                mac_op.c = '0;
            end
            stlg_pkg::ST_READ: rd_en = 1'b1;
            stlg_pkg::ST_NEXT: begin
                wr_addr  = idx_reg;
                wr_en    = out_free;
                out_load = out_free;
            end
            default: s_tready = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stlg_pkg::ST_IDLE;
            fill_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                cnt_reg <= '0;
            end else if (state_reg == stlg_pkg::ST_FILL) begin
                cnt_reg <= cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_LAST) begin
                    fill_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            seed_reg <= s_tdata;
            x_reg    <= s_tdata;
        end else if (state_reg == stlg_pkg::ST_FILL) begin
            x_reg <= lcg_val;
        end
        if (state_reg == stlg_pkg::ST_CALC) begin
            prod_reg <= mac_res;
        end
        if (state_reg == stlg_pkg::ST_READ) begin
            idx_reg <= idx_calc;
        end
        if (wr_en && wr_addr == '0) begin
            e0_reg <= lcg_val;
        end
        if (out_load) begin
            m_data_reg <= rdata_reg;
        end
    end

    // table memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= lcg_val;
        end
        if (rd_en) begin
            rdata_reg <= mem[idx_calc];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_fill_clears_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(fill_reg) |-> $past(state_reg) == stlg_pkg::ST_FILL)
        else $error("fill flag cleared outside the fill sweep");

    a_first_word_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && fill_reg |=> state_reg == stlg_pkg::ST_FILL)
        else $error("first word did not start the table fill");

    a_result_from_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == stlg_pkg::ST_NEXT)
        else $error("result appeared outside the final step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("waiting result overwritten");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stlg_pkg::ST_NEXT |-> idx_reg <= IDX_LAST)
        else $error("table index out of range");
`endif

endmodule

FILE: verif/stlg_checker.sv
`timescale 1ns / 1ps
// checker for the shuffle table lcg generator: predicts each value word and compares
// depends on stlg_pkg; watches the seed and value channels of the block only

module stlg_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] seed
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] value
    output int          fail_count,
    output int          pending
);

    logic [stlg_pkg::WORD_W-1:0] shuffle_words [TABLE_DEPTH];
    logic                        fill_pending = 1'b1;
    logic [stlg_pkg::WORD_W-1:0] due_values [$];
    logic [stlg_pkg::WORD_W-1:0] want_value;
    int                          mismatches = 0;
    int                          due_count = 0;

    assign fail_count = mismatches;
    assign pending    = due_count;

    function automatic logic [stlg_pkg::WORD_W-1:0] lcg_step(
        input logic [stlg_pkg::WORD_W-1:0] z
    );
        return stlg_pkg::LCG_MUL * z + stlg_pkg::LCG_ADD;
    endfunction

    // one draw: fill on first use, index from entry 0, swap in the next lcg value
    function automatic logic [stlg_pkg::WORD_W-1:0] draw_value(
        input logic [stlg_pkg::WORD_W-1:0] seed
    );
        logic [stlg_pkg::WORD_W-1:0] z;
        logic [stlg_pkg::WORD_W-1:0] picked;
        int unsigned                 slot;
        if (fill_pending) begin
            z = seed;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                z = lcg_step(z);
                shuffle_words[i] = z;
            end
            fill_pending = 1'b0;
        end
        slot = (32'(shuffle_words[0]) * 32'(TABLE_DEPTH - 1)) / 32'(stlg_pkg::WORD_MAX);
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        picked = shuffle_words[slot];
        shuffle_words[slot] = lcg_step(seed);
        return picked;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_pending = 1'b1;
            due_values.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_values.size() == 0) begin
                    $error("value: expected none, actual %h", m_tdata);
                    mismatches++;
                end else begin
                    want_value = due_values.pop_front();
                    if (want_value !== m_tdata) begin
                        $error("value: expected %h, actual %h", want_value, m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_values.push_back(draw_value(s_tdata));
        end
        due_count = due_values.size();
    end

endmodule

FILE: verif/shuffle_table_lcg_generator_tb.sv
`timescale 1ns / 1ps
// testbench top for the shuffle table lcg generator: clock, reset, seed stimulus, value sink
// depends on stlg_pkg, stlg_checker and the block under test

module shuffle_table_lcg_generator_tb;

    localparam int DEPTH          = 32;
    // entry 0 values up to this one select entry 0 itself (2114 * 31 < 65535)
    localparam logic [15:0] SELF_TOP = 16'd2114;
    localparam int REGIME_WORDS   = 1500;
    localparam int NOISE_WORDS    = 400;
    localparam int CALM_WORDS     = 150;   // tail of the run without any idling
    localparam int DRAIN_CYCLES   = 40;
    // slowest word is the fill plus the longest sink stall; far below this
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] seed
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] value

    logic        calm = 1'b0;     // set for the last part of the run: no idling at all
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          fail_count;
    int          pending;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    shuffle_table_lcg_generator #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stlg_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // seed whose lcg successor is the wanted word; the multiplier inverse comes
    // from newton steps mod 2^16 (an odd number is its own inverse to 3 bits)
    function automatic logic [15:0] seed_for_entry(input logic [15:0] want);
        logic [15:0] inv;
        inv = stlg_pkg::LCG_MUL;
        repeat (4) inv = inv * (16'd2 - stlg_pkg::LCG_MUL * inv);
        return (want - stlg_pkg::LCG_ADD) * inv;
    endfunction

    // one seed word: optional gap burst, then hold valid until the handshake
    task automatic send_seed(input logic [15:0] seed);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
    endtask

    // value sink: ready with random stall bursts
    always @(posedge aclk) begin
        if (!calm && stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && aresetn && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: a long run of cycles without any handshake means the block hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // entry 0 only changes while it selects itself, so the run first stays in that
    // regime (every new entry 0 kept at or below SELF_TOP), then leaves it through the
    // largest entry 0, after which the index is pinned to the last entry
    initial begin
        logic [15:0] self_words [9];
        logic [15:0] want;

        self_words = '{16'd0, SELF_TOP, 16'd1, 16'd0, SELF_TOP - 16'd1,
                       SELF_TOP, 16'h0400, 16'h0001, 16'h0555};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // first word runs the fill; its seed gives entry 0 = 0 so entry 0 selects itself
        foreach (self_words[i])
            send_seed(seed_for_entry(self_words[i]));

        // well-formed stretch: random entry 0 values that keep selecting entry 0
        repeat (REGIME_WORDS) begin
            if ($urandom_range(0, 7) == 0)
                want = $urandom_range(0, 1) ? SELF_TOP : 16'd0;
            else
                want = 16'($urandom_range(0, SELF_TOP));
            send_seed(seed_for_entry(want));
        end

        // largest entry 0 selects the last entry from here on; then field extremes
        send_seed(seed_for_entry(16'hFFFF));
        send_seed(16'h0000);
        send_seed(16'hFFFF);
        send_seed(16'h5555);
        send_seed(16'hAAAA);

        // noise seeds, the tail with no idling on either side
        for (int n = 0; n < NOISE_WORDS; n++) begin
            if (n == NOISE_WORDS - CALM_WORDS)
                calm = 1'b1;
            send_seed(16'($urandom_range(0, 65535)));
        end
        s_tvalid <= 1'b0;

        // wait for every value word, then a quiet stretch to catch stray words
        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
